// ----- src/top_level_key_locator_top_macros.svh -----
// assertion helpers used by the checker file
`ifndef TOP_LEVEL_KEY_LOCATOR_TOP_MACROS_SVH
`define TOP_LEVEL_KEY_LOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define TLKL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TLKL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tlkl_pkg.sv -----
`timescale 1ns / 1ps
package tlkl_pkg;

  localparam int MAX_MARKER_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF      = 32;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int MARKER_LEN_W = 5;
  localparam int OUT_OFS_W    = 32;
  localparam int DEPTH_W      = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_LEN  = 2'd2;

  localparam logic [MARKER_LEN_W-1:0] MARKER_LEN_RST = 5'd1;

  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7fff;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -16'sh8000;
  localparam logic signed [DEPTH_W-1:0] DEPTH_ONE = 16'sh0001;

  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;
  localparam logic [7:0] CH_LBRACK  = 8'h5b;
  localparam logic [7:0] CH_RBRACK  = 8'h5d;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;

endpackage

// ----- src/top_level_key_locator_top.sv -----
`timescale 1ns / 1ps
// top-level key locator: one text byte per cycle while in_stall is low, scan state updated as the byte is taken
// a result is registered into the output register, or into the skid entry while a stalled result holds it
// throughput: one byte per cycle; a two-entry output buffer (output register plus skid)
// keeps input flowing while a result waits; in_stall rises only when both entries are full
// reset (rst_n low, synchronous): scan state cleared, marker bytes zero, marker length one
module top_level_key_locator_top
  import tlkl_pkg::*;
#(
  parameter int MAX_MARKER_BYTES = MAX_MARKER_BYTES_DEF,
  parameter int OFFSET_BITS      = OFFSET_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_text_byte,
  input  logic                    in_slice_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic [OUT_OFS_W-1:0]    out_field_offset,
  output logic [OUT_OFS_W-1:0]    out_value_offset,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = (MAX_MARKER_BYTES > 1) ? $clog2(MAX_MARKER_BYTES) : 1;

  logic [CFG_DATA_W-1:0]   marker_lo_r, marker_hi_r;
  logic [MARKER_LEN_W-1:0] marker_len_r;

  logic [OFFSET_BITS-1:0]    pos_r, pos_nxt;
  logic                      in_str_r, in_str_nxt;
  logic                      sq_r, sq_nxt;
  logic                      esc_r, esc_nxt;
  logic signed [DEPTH_W-1:0] brace_r, brace_nxt;
  logic signed [DEPTH_W-1:0] bracket_r, bracket_nxt;
  logic [7:0]                recent_r [MAX_MARKER_BYTES];
  logic [7:0]                recent_nxt [MAX_MARKER_BYTES];
  logic [MAX_MARKER_BYTES-1:0] elig_r, elig_nxt;
  logic                      done_r, done_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [OUT_OFS_W-1:0]   out_field_r, out_field_nxt;
  logic [OUT_OFS_W-1:0]   out_value_r, out_value_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  logic                   skid_found_r, skid_found_nxt;
  logic [OUT_OFS_W-1:0]   skid_field_r, skid_field_nxt;
  logic [OUT_OFS_W-1:0]   skid_value_r, skid_value_nxt;

  logic                   acc;
  logic [7:0]             mk [MAX_MARKER_BYTES];
  logic [7:0]             win [MAX_MARKER_BYTES];
  logic [MAX_MARKER_BYTES-1:0] ewin;
  logic [MARKER_LEN_W-1:0] len_c;
  logic                   byte_elig;
  logic                   hit;
  logic                   res_vld, res_found;
  logic [OUT_OFS_W-1:0]   res_field, res_value;
  logic [OFFSET_BITS-1:0] start_pos, end_pos;

  assign acc       = in_valid && !in_stall;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_field_offset = out_field_r;
  assign out_value_offset = out_value_r;

  // marker bytes beyond the two registers read as zero
  always_comb begin
    for (int i = 0; i < MAX_MARKER_BYTES; i++) begin
      if (i < 8) begin
        mk[i] = marker_lo_r[8*i +: 8];
      end else if (i < 16) begin
        mk[i] = marker_hi_r[8*(i-8) +: 8];
      end else begin
        mk[i] = 8'h00;
      end
    end
  end

  assign len_c = (32'(marker_len_r) > MAX_MARKER_BYTES) ? MARKER_LEN_W'(MAX_MARKER_BYTES)
                                                         : marker_len_r;

  // byte classification outside strings: only plain bytes at top level may start the marker
  assign byte_elig = !in_str_r && (in_text_byte != CH_DQUOTE) && (in_text_byte != CH_SQUOTE)
                     && (in_text_byte != CH_LBRACE) && (in_text_byte != CH_RBRACE)
                     && (in_text_byte != CH_LBRACK) && (in_text_byte != CH_RBRACK)
                     && (brace_r == DEPTH_ONE) && (bracket_r == '0);

  // window after shifting in the current byte, index 0 newest
  always_comb begin
    win[0]  = in_text_byte;
    ewin[0] = byte_elig;
    for (int k = 1; k < MAX_MARKER_BYTES; k++) begin
      win[k]  = recent_r[k-1];
      ewin[k] = elig_r[k-1];
    end
  end

  always_comb begin
    logic [6:0] sel;
    logic [6:0] k;
    logic       same;
    sel  = 7'(len_c) - 7'd1;
    same = 1'b1;
    for (int j = 0; j < MAX_MARKER_BYTES; j++) begin
      k = sel - 7'(j);
      if (7'(j) < 7'(len_c)) begin
        if (win[j] != mk[k[IDX_W-1:0]]) begin
          same = 1'b0;
        end
      end
    end
    hit = (len_c != '0) && ewin[sel[IDX_W-1:0]] && same;
  end

  assign start_pos = pos_r - OFFSET_BITS'(len_c - MARKER_LEN_W'(1));
  assign end_pos   = start_pos + OFFSET_BITS'(len_c);

  always_comb begin
    pos_nxt     = pos_r;
    in_str_nxt  = in_str_r;
    sq_nxt      = sq_r;
    esc_nxt     = esc_r;
    brace_nxt   = brace_r;
    bracket_nxt = bracket_r;
    recent_nxt  = recent_r;
    elig_nxt    = elig_r;
    done_nxt    = done_r;
    res_vld     = 1'b0;
    res_found   = 1'b0;
    res_field   = '0;
    res_value   = '0;

    if (acc && !done_r) begin
      if (in_str_r) begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (in_text_byte == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (in_text_byte == (sq_r ? CH_SQUOTE : CH_DQUOTE)) begin
          in_str_nxt = 1'b0;
        end
      end else if (in_text_byte == CH_DQUOTE || in_text_byte == CH_SQUOTE) begin
        in_str_nxt = 1'b1;
        sq_nxt     = (in_text_byte == CH_SQUOTE);
      end else if (in_text_byte == CH_LBRACE) begin
        if (brace_r != DEPTH_MAX) brace_nxt = brace_r + DEPTH_ONE;
      end else if (in_text_byte == CH_RBRACE) begin
        if (brace_r != DEPTH_MIN) brace_nxt = brace_r - DEPTH_ONE;
      end else if (in_text_byte == CH_LBRACK) begin
        if (bracket_r != DEPTH_MAX) bracket_nxt = bracket_r + DEPTH_ONE;
      end else if (in_text_byte == CH_RBRACK) begin
        if (bracket_r != DEPTH_MIN) bracket_nxt = bracket_r - DEPTH_ONE;
      end

      recent_nxt = win;
      elig_nxt   = ewin;
      pos_nxt    = pos_r + OFFSET_BITS'(1);

      if (hit) begin
        done_nxt  = 1'b1;
        res_vld   = 1'b1;
        res_found = 1'b1;
        res_field = OUT_OFS_W'(start_pos);
        res_value = OUT_OFS_W'(end_pos);
      end else if (in_slice_last) begin
        // slice ended with no match: report not found
        res_vld = 1'b1;
      end
    end

    // slice end returns scan state to its start
    if (acc && in_slice_last) begin
      pos_nxt     = '0;
      in_str_nxt  = 1'b0;
      sq_nxt      = 1'b0;
      esc_nxt     = 1'b0;
      brace_nxt   = '0;
      bracket_nxt = '0;
      elig_nxt    = '0;
      done_nxt    = 1'b0;
    end
  end

  // output register plus skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_field_nxt  = out_field_r;
    out_value_nxt  = out_value_r;
    skid_valid_nxt = skid_valid_r;
    skid_found_nxt = skid_found_r;
    skid_field_nxt = skid_field_r;
    skid_value_nxt = skid_value_r;
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt  = skid_valid_r || res_vld;
      out_found_nxt  = skid_valid_r ? skid_found_r : res_found;
      out_field_nxt  = skid_valid_r ? skid_field_r : res_field;
      out_value_nxt  = skid_valid_r ? skid_value_r : res_value;
      skid_valid_nxt = 1'b0;
    end else if (res_vld) begin
      skid_valid_nxt = 1'b1;
      skid_found_nxt = res_found;
      skid_field_nxt = res_field;
      skid_value_nxt = res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_lo_r  <= '0;
      marker_hi_r  <= '0;
      marker_len_r <= MARKER_LEN_RST;
      pos_r        <= '0;
      in_str_r     <= 1'b0;
      sq_r         <= 1'b0;
      esc_r        <= 1'b0;
      brace_r      <= '0;
      bracket_r    <= '0;
      elig_r       <= '0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MARKER_LOW:  marker_lo_r  <= cfg_data;
          REG_MARKER_HIGH: marker_hi_r  <= cfg_data;
          REG_MARKER_LEN:  marker_len_r <= cfg_data[MARKER_LEN_W-1:0];
          default: ;
        endcase
      end
      pos_r        <= pos_nxt;
      in_str_r     <= in_str_nxt;
      sq_r         <= sq_nxt;
      esc_r        <= esc_nxt;
      brace_r      <= brace_nxt;
      bracket_r    <= bracket_nxt;
      elig_r       <= elig_nxt;
      done_r       <= done_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    recent_r     <= recent_nxt;
    out_found_r  <= out_found_nxt;
    out_field_r  <= out_field_nxt;
    out_value_r  <= out_value_nxt;
    skid_found_r <= skid_found_nxt;
    skid_field_r <= skid_field_nxt;
    skid_value_r <= skid_value_nxt;
  end

endmodule

// ----- src/tlkl_checker.sv -----
`timescale 1ns / 1ps
`include "top_level_key_locator_top_macros.svh"
module tlkl_checker
  import tlkl_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_found,
  input logic [OUT_OFS_W-1:0]  out_field_offset,
  input logic [OUT_OFS_W-1:0]  out_value_offset
);

  // not-found result carries zero offsets
  `TLKL_ASSERT_NOW(a_notfound_zero, out_valid && !out_found,
    out_field_offset == '0 && out_value_offset == '0, "not-found result with nonzero offsets")

  // a located marker always has nonzero length
  `TLKL_ASSERT_NOW(a_found_len, out_valid && out_found,
    out_value_offset != out_field_offset, "found result with empty marker span")

  // input only backs up once the output register is occupied
  `TLKL_ASSERT_NOW(a_stall_needs_out, in_stall, out_valid, "input stalled with empty output")

  // a stalled result holds
  `TLKL_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_found) && $stable(out_field_offset)
    && $stable(out_value_offset), "stalled result changed")

endmodule

bind top_level_key_locator_top tlkl_checker u_tlkl_checker (.*);
